[sv/jrf_pkg.sv]
// ----------------------------------------------------------------------------
// jrf_pkg
// Shared types and constants for the request framer: register indexes, reset
// values of the marker registers, and the burst and packet state records.
// ----------------------------------------------------------------------------
package jrf_pkg;

  // Width of a wire byte
  localparam int unsigned ByteW = 8;

  // Most wire bytes one input transaction can produce (header with checksum)
  localparam int unsigned BurstMax = 4;
  localparam int unsigned CountW   = $clog2(BurstMax + 1);

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegSync   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEscape = 2'd1;

  // Marker reset values
  localparam logic [ByteW-1:0] SyncReset   = 8'hE0;
  localparam logic [ByteW-1:0] EscapeReset = 8'hD0;

  // Input opcodes
  localparam logic OpHeader  = 1'b0;
  localparam logic OpPayload = 1'b1;

  // Packet bookkeeping carried between transactions
  typedef struct packed {
    logic [ByteW-1:0] bytes_left;
    logic [ByteW-1:0] running_sum;
    logic             packet_open;
  } pkt_state_t;

  // Wire bytes produced by one transaction, sent from entry 0 upward
  typedef struct packed {
    logic [BurstMax-1:0][ByteW-1:0] bytes;
    logic [CountW-1:0]              count;
    logic                           last;   // final byte of the burst is a checksum
  } burst_t;

endpackage

[sv/jrf_encode.sv]
// ----------------------------------------------------------------------------
// jrf_encode
// Turns one input transaction and the current packet state into a burst of
// wire bytes (framing, escaping, checksum) and the next packet state.
// ----------------------------------------------------------------------------
module jrf_encode (
  input  logic                       op_i,
  input  logic [jrf_pkg::ByteW-1:0]  dest_addr_i,
  input  logic [jrf_pkg::ByteW-1:0]  payload_length_i,
  input  logic [jrf_pkg::ByteW-1:0]  data_byte_i,
  input  logic [jrf_pkg::ByteW-1:0]  sync_byte_i,
  input  logic [jrf_pkg::ByteW-1:0]  escape_byte_i,
  input  jrf_pkg::pkt_state_t        state_i,
  output jrf_pkg::pkt_state_t        state_o,
  output jrf_pkg::burst_t            burst_o
);

  logic [jrf_pkg::ByteW-1:0] byte_count;
  logic [jrf_pkg::ByteW-1:0] hdr_sum;
  logic [jrf_pkg::ByteW-1:0] pay_sum;
  logic [jrf_pkg::ByteW-1:0] pay_left;
  logic                      needs_esc;
  logic                      pay_done;
  logic                      hdr_done;

  // Header arithmetic: byte count wraps with the length
  assign byte_count = payload_length_i + 8'd1;
  assign hdr_sum    = dest_addr_i + byte_count;
  assign hdr_done   = (payload_length_i == '0);

  // Payload arithmetic
  assign needs_esc = (data_byte_i == sync_byte_i) || (data_byte_i == escape_byte_i);
  assign pay_sum   = state_i.running_sum + data_byte_i;
  assign pay_left  = state_i.bytes_left - 8'd1;
  assign pay_done  = (pay_left == '0);

  // Build the burst and the next state
  always_comb begin
    state_o = state_i;
    burst_o = '0;
    if (op_i == jrf_pkg::OpHeader) begin
      burst_o.bytes[0]    = sync_byte_i;
      burst_o.bytes[1]    = dest_addr_i;
      burst_o.bytes[2]    = byte_count;
      burst_o.bytes[3]    = hdr_sum;
      burst_o.count       = hdr_done ? 3'd4 : 3'd3;
      burst_o.last        = hdr_done;
      state_o.running_sum = hdr_sum;
      state_o.bytes_left  = payload_length_i;
      state_o.packet_open = !hdr_done;
    end else if (state_i.packet_open) begin
      // Escaped bytes go out as marker then byte minus one
      burst_o.bytes[0]    = needs_esc ? escape_byte_i : data_byte_i;
      burst_o.bytes[1]    = needs_esc ? (data_byte_i - 8'd1) : pay_sum;
      burst_o.bytes[2]    = pay_sum;
      burst_o.count       = 3'd1 + {2'b00, needs_esc} + {2'b00, pay_done};
      burst_o.last        = pay_done;
      state_o.running_sum = pay_sum;
      state_o.bytes_left  = pay_left;
      state_o.packet_open = !pay_done;
    end
  end

endmodule

[sv/jrf_serializer.sv]
// ----------------------------------------------------------------------------
// jrf_serializer
// Holds one burst of wire bytes and hands them out one per transaction on
// the output channel. Takes a new burst when empty or on its final byte.
// ----------------------------------------------------------------------------
module jrf_serializer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  jrf_pkg::burst_t           burst_i,
  output logic                      can_load_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [jrf_pkg::ByteW-1:0] out_byte_o,
  output logic                      last_o
);

  logic [jrf_pkg::BurstMax-1:0][jrf_pkg::ByteW-1:0] buf_q, buf_d;
  logic [jrf_pkg::CountW-1:0]                       count_q, count_d;
  logic                                             last_q, last_d;
  logic                                             pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = (count_q == '0) || ((count_q == 3'd1) && out_ready_i);
  assign out_byte_o  = buf_q[0];
  assign last_o      = last_q && (count_q == 3'd1);

  // Load a new burst or advance to the next byte
  always_comb begin
    buf_d   = buf_q;
    count_d = count_q;
    last_d  = last_q;
    if (load_i) begin
      buf_d   = burst_i.bytes;
      count_d = burst_i.count;
      last_d  = burst_i.last;
    end else if (pop) begin
      buf_d   = buf_q >> jrf_pkg::ByteW;
      count_d = count_q - 3'd1;
    end
  end

  // Hold byte count and end flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      last_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  // Byte buffer needs no reset
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

[sv/jvs_request_framer.sv]
// ----------------------------------------------------------------------------
// jvs_request_framer
// Frames request packets as a wire byte stream with sync, escape and checksum.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    op, dest_addr, payload_length, data_byte
// out       output     out_valid/out_ready  out_byte, last
// cfg       input      cfg_we               cfg_index, cfg_data
//
// An input transaction is encoded in the cycle it is taken; its bytes leave
// from the burst register one per cycle while out_ready is high: a header
// gives 3 or 4 wire bytes, a payload byte 1 to 3, a stray payload byte none.
// The next transaction is taken in the cycle the final byte of the current
// burst leaves, so the output rate of one wire byte per cycle sets the pace.
// Reset clears the packet state and restores the marker registers; output
// stalls hold the current byte and block input.
// ----------------------------------------------------------------------------
module jvs_request_framer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration writes
  input  logic                        cfg_we_i,
  input  logic [jrf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [jrf_pkg::ByteW-1:0]   cfg_data_i,
  // Input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [jrf_pkg::ByteW-1:0]   dest_addr_i,
  input  logic [jrf_pkg::ByteW-1:0]   payload_length_i,
  input  logic [jrf_pkg::ByteW-1:0]   data_byte_i,
  // Wire bytes
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [jrf_pkg::ByteW-1:0]   out_byte_o,
  output logic                        last_o
);

  logic [jrf_pkg::ByteW-1:0] sync_q;
  logic [jrf_pkg::ByteW-1:0] escape_q;
  jrf_pkg::pkt_state_t       state_q, state_d;
  jrf_pkg::burst_t           burst;
  logic                      in_accept;

  assign in_accept = in_valid_i && in_ready_o;

  // Marker registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= jrf_pkg::SyncReset;
      escape_q <= jrf_pkg::EscapeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        jrf_pkg::RegSync:   sync_q   <= cfg_data_i;
        jrf_pkg::RegEscape: escape_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Packet state advances on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  jrf_encode u_encode (
    .op_i             (op_i),
    .dest_addr_i      (dest_addr_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .sync_byte_i      (sync_q),
    .escape_byte_i    (escape_q),
    .state_i          (state_q),
    .state_o          (state_d),
    .burst_o          (burst)
  );

  jrf_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_accept),
    .burst_i     (burst),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

[sv/jrf_checker.sv]
// ----------------------------------------------------------------------------
// jrf_checker
// Port-level checks on the request framer, bound to the top level.
// ----------------------------------------------------------------------------
module jrf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      op_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [jrf_pkg::ByteW-1:0] out_byte_o,
  input logic                      last_o
);

  // Stalled output byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled output transaction changed");

  // Input is taken only when the pending burst drains this cycle
  a_in_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input taken while output byte still pending");

  // A header always produces bytes next cycle
  a_hdr_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == jrf_pkg::OpHeader) |=> out_valid_o)
    else $error("header produced no wire bytes");

  // The sync byte of a header burst is never flagged as the final byte
  a_hdr_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == jrf_pkg::OpHeader) |=> !last_o)
    else $error("sync byte flagged as packet end");

endmodule

bind jvs_request_framer jrf_checker u_jrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o)
);
